// ===== rtl/rtlm_pkg.sv =====
package rtlm_pkg;

  // default sizes
  localparam int DEF_MAX_CELLS   = 256;
  localparam int DEF_MAX_OUT_DIM = 1024;
  localparam int DEF_COORD_WIDTH = 32;

  // field widths
  localparam int AXIS_W  = 2;
  localparam int POS_W   = 9;
  localparam int BVAL_W  = 32;
  localparam int VOX_W   = 10;
  localparam int SIDX_W  = 24;
  localparam int CELL_W  = 8;

  // register widths and APB
  localparam int CFG_CELLS_W = 9;
  localparam int CFG_DIM_W   = 11;
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;
  localparam int REG_IDX_W   = 3;

  localparam logic [REG_IDX_W-1:0] REG_IN_CELLS_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_IN_CELLS_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_IN_CELLS_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_OUT_DIM_X  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_OUT_DIM_Y  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_OUT_DIM_Z  = 3'd5;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_MAP   = 1'b1;

  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic [2:0][CFG_CELLS_W-1:0] cells;
    logic [2:0][CFG_DIM_W-1:0]   dims;
  } cfg_t;

endpackage

// ===== rtl/rtlm_if.sv =====
interface rtlm_in_if;
  import rtlm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [AXIS_W-1:0]          axis;
  logic [POS_W-1:0]           bound_position;
  logic signed [BVAL_W-1:0]   bound_value;
  logic [VOX_W-1:0]           voxel_x;
  logic [VOX_W-1:0]           voxel_y;
  logic [VOX_W-1:0]           voxel_z;

  modport source (output valid, operation, axis, bound_position, bound_value,
                  voxel_x, voxel_y, voxel_z, input ready);
  modport sink (input valid, operation, axis, bound_position, bound_value,
                voxel_x, voxel_y, voxel_z, output ready);
endinterface

interface rtlm_out_if;
  import rtlm_pkg::*;
  logic              valid;
  logic              ready;
  logic [SIDX_W-1:0] source_index;
  logic [CELL_W-1:0] cell_x;
  logic [CELL_W-1:0] cell_y;
  logic [CELL_W-1:0] cell_z;

  modport source (output valid, source_index, cell_x, cell_y, cell_z, input ready);
  modport sink (input valid, source_index, cell_x, cell_y, cell_z, output ready);
endinterface

// ===== rtl/rectilinear_to_regular_index_map_top.sv =====
// Maps voxels of a uniform output grid onto cells of a rectilinear input grid.
// Write words (operation 0) store one boundary coordinate.
// A map word (operation 1) runs a linear scan of each axis' bounds in turn on
// one shared multiplier and one shared bound read address, the scan stopping
// at the first matching cell. ready stays low meanwhile; a finished result
// waits in the output register while the next word enters.
module rectilinear_to_regular_index_map_top #(
  parameter int MAX_CELLS   = rtlm_pkg::DEF_MAX_CELLS,
  parameter int MAX_OUT_DIM = rtlm_pkg::DEF_MAX_OUT_DIM,
  parameter int COORD_WIDTH = rtlm_pkg::DEF_COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rtlm_pkg::PADDR_W-1:0]  paddr,
  input  logic [rtlm_pkg::PDATA_W-1:0]  pwdata,
  output logic [rtlm_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  rtlm_in_if.sink                       map_in,
  rtlm_out_if.source                    map_out
);
  import rtlm_pkg::*;

  localparam int CNT_W = $clog2(MAX_CELLS + 1);

  cfg_t                         cfg;
  logic                         accept;
  logic                         wr_ok;
  logic                         start;
  logic [CNT_W-1:0]             rd_addr;
  logic signed [COORD_WIDTH-1:0] rd_data [3];
  logic [2:0][VOX_W-1:0]        voxel;
  logic [AXIS_W-1:0]            axis_code [3];

  assign axis_code[0] = AXIS_X;
  assign axis_code[1] = AXIS_Y;
  assign axis_code[2] = AXIS_Z;

  assign accept = map_in.valid & map_in.ready;
  assign start  = accept & (map_in.operation == OP_MAP);
  assign wr_ok  = accept & (map_in.operation == OP_WRITE)
                  & (32'(map_in.bound_position) <= MAX_CELLS);
  assign voxel  = {map_in.voxel_z, map_in.voxel_y, map_in.voxel_x};

  rtlm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // word cut to COORD_WIDTH bits, sign taken from bit COORD_WIDTH-1
  for (genvar g = 0; g < 3; g++) begin : g_bounds
    rtlm_ram #(.WIDTH(COORD_WIDTH), .DEPTH(MAX_CELLS + 1)) u_ram (
      .clk   (clk),
      .we    (wr_ok && (map_in.axis == axis_code[g])),
      .waddr (CNT_W'(map_in.bound_position)),
      .wdata (COORD_WIDTH'($unsigned(map_in.bound_value))),
      .raddr (rd_addr),
      .rdata (rd_data[g])
    );
  end

  rtlm_seq #(
    .MAX_CELLS   (MAX_CELLS),
    .MAX_OUT_DIM (MAX_OUT_DIM),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .voxel        (voxel),
    .cfg          (cfg),
    .ready        (map_in.ready),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .out_valid    (map_out.valid),
    .out_ready    (map_out.ready),
    .source_index (map_out.source_index),
    .cell_x       (map_out.cell_x),
    .cell_y       (map_out.cell_y),
    .cell_z       (map_out.cell_z)
  );
endmodule

// ===== rtl/rtlm_ram.sv =====
module rtlm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 257
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/rtlm_mul.sv =====
module rtlm_mul #(
  parameter int A_W = 33,
  parameter int B_W = 13
) (
  input  logic                     clk,
  input  logic signed [A_W-1:0]    a,
  input  logic signed [B_W-1:0]    b,
  output logic signed [A_W+B_W-1:0] prod
);
  always_ff @(posedge clk) begin
    prod <= a * b;
  end
endmodule

// ===== rtl/rtlm_cfg.sv =====
module rtlm_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rtlm_pkg::PADDR_W-1:0]  paddr,
  input  logic [rtlm_pkg::PDATA_W-1:0]  pwdata,
  output logic [rtlm_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output rtlm_pkg::cfg_t                cfg
);
  import rtlm_pkg::*;

  logic                 wr;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cells <= {3{CFG_CELLS_W'(1)}};
      cfg.dims  <= {3{CFG_DIM_W'(1)}};
    end else if (wr) begin
      unique case (idx)
        REG_IN_CELLS_X: cfg.cells[0] <= pwdata[CFG_CELLS_W-1:0];
        REG_IN_CELLS_Y: cfg.cells[1] <= pwdata[CFG_CELLS_W-1:0];
        REG_IN_CELLS_Z: cfg.cells[2] <= pwdata[CFG_CELLS_W-1:0];
        REG_OUT_DIM_X:  cfg.dims[0]  <= pwdata[CFG_DIM_W-1:0];
        REG_OUT_DIM_Y:  cfg.dims[1]  <= pwdata[CFG_DIM_W-1:0];
        REG_OUT_DIM_Z:  cfg.dims[2]  <= pwdata[CFG_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_IN_CELLS_X: prdata = PDATA_W'(cfg.cells[0]);
      REG_IN_CELLS_Y: prdata = PDATA_W'(cfg.cells[1]);
      REG_IN_CELLS_Z: prdata = PDATA_W'(cfg.cells[2]);
      REG_OUT_DIM_X:  prdata = PDATA_W'(cfg.dims[0]);
      REG_OUT_DIM_Y:  prdata = PDATA_W'(cfg.dims[1]);
      REG_OUT_DIM_Z:  prdata = PDATA_W'(cfg.dims[2]);
      default:        prdata = '0;
    endcase
  end
endmodule

// ===== rtl/rtlm_seq.sv =====
module rtlm_seq #(
  parameter int MAX_CELLS   = rtlm_pkg::DEF_MAX_CELLS,
  parameter int MAX_OUT_DIM = rtlm_pkg::DEF_MAX_OUT_DIM,
  parameter int COORD_WIDTH = rtlm_pkg::DEF_COORD_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [2:0][rtlm_pkg::VOX_W-1:0]       voxel,
  input  rtlm_pkg::cfg_t                        cfg,
  output logic                                  ready,
  output logic [$clog2(MAX_CELLS+1)-1:0]        rd_addr,
  input  logic signed [COORD_WIDTH-1:0]         rd_data [3],
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [rtlm_pkg::SIDX_W-1:0]           source_index,
  output logic [rtlm_pkg::CELL_W-1:0]           cell_x,
  output logic [rtlm_pkg::CELL_W-1:0]           cell_y,
  output logic [rtlm_pkg::CELL_W-1:0]           cell_z
);
  import rtlm_pkg::*;

  localparam int CNT_W = $clog2(MAX_CELLS + 1);
  localparam int K_W   = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int DIM_W = $clog2(MAX_OUT_DIM + 1);
  localparam int B_W0  = (DIM_W + 2 > CNT_W + 1) ? DIM_W + 2 : CNT_W + 1;
  localparam int B_W   = (B_W0 > VOX_W + 2) ? B_W0 : VOX_W + 2;
  localparam int A_W   = (COORD_WIDTH + 1 > 2 * CNT_W + 1) ? COORD_WIDTH + 1 : 2 * CNT_W + 1;
  localparam int P_W   = A_W + B_W;
  localparam int C_W   = P_W + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WL   = 4'd1;
  localparam logic [3:0] S_LL   = 4'd2;
  localparam logic [3:0] S_LF   = 4'd3;
  localparam logic [3:0] S_M1   = 4'd4;
  localparam logic [3:0] S_M2   = 4'd5;
  localparam logic [3:0] S_SM   = 4'd6;
  localparam logic [3:0] S_SC   = 4'd7;
  localparam logic [3:0] S_IX0  = 4'd8;
  localparam logic [3:0] S_IX1  = 4'd9;
  localparam logic [3:0] S_IX2  = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [3:0]                  st;
  logic [1:0]                  ax;
  logic [CNT_W-1:0]            j;
  logic [2:0][VOX_W-1:0]       vox;
  logic signed [COORD_WIDTH-1:0] first_v, last_v;
  logic signed [C_W-1:0]       centre;
  logic                        prev_lt;
  logic [K_W-1:0]              k [3];
  logic [SIDX_W-1:0]           idx;

  logic [CNT_W-1:0]            cells_c [3];
  logic [DIM_W-1:0]            dims_c [3];
  logic [CNT_W-1:0]            cells_cur;
  logic [DIM_W:0]              d2;
  logic signed [COORD_WIDTH-1:0] rdata_cur;
  logic signed [A_W-1:0]       a_op;
  logic signed [B_W-1:0]       b_op;
  logic signed [P_W-1:0]       prod;
  logic                        lt, ge, hit, ax_done;
  logic                        load_out;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (cfg.cells[a] == '0) begin
        cells_c[a] = CNT_W'(1);
      end else if (32'(cfg.cells[a]) > MAX_CELLS) begin
        cells_c[a] = CNT_W'(MAX_CELLS);
      end else begin
        cells_c[a] = CNT_W'(cfg.cells[a]);
      end
      if (cfg.dims[a] == '0) begin
        dims_c[a] = DIM_W'(1);
      end else if (32'(cfg.dims[a]) > MAX_OUT_DIM) begin
        dims_c[a] = DIM_W'(MAX_OUT_DIM);
      end else begin
        dims_c[a] = DIM_W'(cfg.dims[a]);
      end
    end
  end

  assign cells_cur = cells_c[ax];
  assign d2        = {dims_c[ax], 1'b0};
  assign rdata_cur = rd_data[ax];

  // both sides of each compare scaled by 2*out_dim
  assign lt      = C_W'(prod) < centre;
  assign ge      = centre <= C_W'(prod);
  assign hit     = (j != '0) && prev_lt && ge;
  assign ax_done = hit || (j == cells_cur);

  assign load_out = (st == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    a_op = '0;
    b_op = '0;
    case (st)
      S_LF, S_SM: begin
        a_op = A_W'(rdata_cur);
        b_op = B_W'(d2);
      end
      S_M1: begin
        a_op = A_W'(last_v) - A_W'(first_v);
        b_op = B_W'({vox[ax], 1'b1});
      end
      S_IX0: begin
        a_op = A_W'(k[2]);
        b_op = B_W'(cells_c[1]);
      end
      S_IX1: begin
        a_op = A_W'(k[1]) + A_W'(prod);
        b_op = B_W'(cells_c[0]);
      end
      default: ;
    endcase
  end

  rtlm_mul #(.A_W(A_W), .B_W(B_W)) u_mul (
    .clk  (clk),
    .a    (a_op),
    .b    (b_op),
    .prod (prod)
  );

  assign ready = (st == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (start) begin
            vox     <= voxel;
            ax      <= 2'd0;
            rd_addr <= cells_c[0];
            st      <= S_WL;
          end
        end
        S_WL: begin
          rd_addr <= '0;
          st      <= S_LL;
        end
        S_LL: begin
          last_v <= rdata_cur;
          st     <= S_LF;
        end
        S_LF: begin
          first_v <= rdata_cur;
          st      <= S_M1;
        end
        S_M1: begin
          centre <= C_W'(prod);
          st     <= S_M2;
        end
        S_M2: begin
          centre  <= centre + C_W'(prod);
          j       <= '0;
          prev_lt <= 1'b0;
          st      <= S_SM;
        end
        S_SM: begin
          rd_addr <= (j == cells_cur) ? j : j + 1'b1;
          st      <= S_SC;
        end
        S_SC: begin
          prev_lt <= lt;
          if (ax_done) begin
            k[ax] <= hit ? K_W'(j - 1'b1) : '0;
            if (ax == 2'd2) begin
              st <= S_IX0;
            end else begin
              ax      <= ax + 1'b1;
              rd_addr <= cells_c[ax + 1'b1];
              st      <= S_WL;
            end
          end else begin
            j  <= j + 1'b1;
            st <= S_SM;
          end
        end
        S_IX0: st <= S_IX1;
        S_IX1: st <= S_IX2;
        S_IX2: begin
          idx <= SIDX_W'(k[0]) + SIDX_W'(prod);
          st  <= S_DONE;
        end
        S_DONE: begin
          if (load_out) begin
            source_index <= idx;
            cell_x       <= CELL_W'(k[0]);
            cell_y       <= CELL_W'(k[1]);
            cell_z       <= CELL_W'(k[2]);
            st           <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start |=> !ready) else $error("accepted map word did not drop ready");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (st == S_SC) |-> (j <= cells_cur)) else $error("bound scan ran past last bound");

  a_cells_in_range: assert property (@(posedge clk) disable iff (rst)
    (st == S_IX0) |-> (CNT_W'(k[0]) < cells_c[0] && CNT_W'(k[1]) < cells_c[1]
                       && CNT_W'(k[2]) < cells_c[2]))
    else $error("cell index beyond cell count");
endmodule
